[sv/nprf_pkg.sv]
// ----------------------------------------------------------------------------
// nprf_pkg
// Shared types, constants and tables for the note-to-pitch converter.
// ----------------------------------------------------------------------------
package nprf_pkg;

	localparam int MIDI_W     = 7;
	localparam int MIDI_FIX_W = 15;
	localparam int FREQ_W     = 22;
	localparam int OCT_W      = 5;
	localparam int LETTER_W   = 3;
	localparam int ACC_W      = 2;

	// accidental codes
	localparam logic [ACC_W-1:0] ACC_NATURAL = 2'd0;
	localparam logic [ACC_W-1:0] ACC_SHARP   = 2'd1;
	localparam logic [ACC_W-1:0] ACC_FLAT    = 2'd2;

	// result used for leading rests of a sequence that never has a note (160 Hz)
	localparam logic [MIDI_FIX_W-1:0] DEFAULT_MIDI_FIXED   = 15'd13181;
	localparam logic [MIDI_W-1:0]     DEFAULT_MIDI_ROUNDED = 7'd51;
	localparam logic [FREQ_W-1:0]     DEFAULT_FREQ_FIXED   = 22'd40960;

	localparam logic [MIDI_W-1:0] MIDI_MAX = 7'd127;

	// frequency of MIDI 0..11, scaled by 2^28
	localparam logic [31:0] FREQ_BASE [12] = '{
		32'd2194674310, 32'd2325176436, 32'd2463438621, 32'd2609922305,
		32'd2765116361, 32'd2929538736, 32'd3103738174, 32'd3288296050,
		32'd3483828309, 32'd3690987520, 32'd3910465059, 32'd4142993412
	};

	typedef logic [FREQ_W-1:0] freq_tab_t [128];

	// frequency per MIDI number, Hz with 8 fraction bits, rounded half up
	function automatic freq_tab_t build_freq_table();
		freq_tab_t   tab;
		logic [63:0] v;
		int          oct_idx;
		int          pc;
		for (int m = 0; m < 128; m++) begin
			oct_idx = m / 12;
			pc      = m % 12;
			v       = ({32'd0, FREQ_BASE[pc]} << oct_idx) + (64'd1 << 19);
			tab[m]  = v[FREQ_W+19:20];
		end
		return tab;
	endfunction

	localparam freq_tab_t FREQ_TABLE = build_freq_table();

	// pitch class of a natural letter; code 7 reads as B
	function automatic logic [3:0] letter_base(input logic [LETTER_W-1:0] letter);
		logic [3:0] pc;
		case (letter)
			3'd0:    pc = 4'd0;
			3'd1:    pc = 4'd2;
			3'd2:    pc = 4'd4;
			3'd3:    pc = 4'd5;
			3'd4:    pc = 4'd7;
			3'd5:    pc = 4'd9;
			default: pc = 4'd11;
		endcase
		return pc;
	endfunction

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic emit_fill;
		logic emit_final;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;
		logic fill_start;
		logic final_start;
		logic cnt_one;
		logic tok_rest;
	} ctrl_stat_t;

endpackage

[sv/note_to_pitch_rest_fill.sv]
// ----------------------------------------------------------------------------
// note_to_pitch_rest_fill
// Note/rest token stream to MIDI pitch and frequency, with rest filling.
// ----------------------------------------------------------------------------
// Each token is accepted by the sequencer in its idle state, and every result
// it causes is then loaded into the single output register: a note or a rest
// after a note gives one result, a leading rest that ends no sequence gives
// none and is held, and a note released after k held leading rests (or a
// rest-only sequence end with k rests) gives k + 1 (or k) results, each loaded
// only while the output register is free. The sequencer loads the output
// register at most once per cycle and accepts the next token as soon as the
// last result of the current one is loaded, even if that result has not yet
// been taken. Frequencies come from a 128-entry constant table; a sequence
// that ends without a note releases its rests at 160 Hz.
module note_to_pitch_rest_fill #(
	parameter int MAX_LEADING_RESTS = 63
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                is_rest,
	input  logic [nprf_pkg::LETTER_W-1:0]       note_letter,
	input  logic [nprf_pkg::ACC_W-1:0]          accidental,
	input  logic signed [nprf_pkg::OCT_W-1:0]   octave,
	input  logic                                last_token,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [nprf_pkg::MIDI_FIX_W-1:0]     midi_fixed,
	output logic [nprf_pkg::MIDI_W-1:0]         midi_rounded,
	output logic [nprf_pkg::FREQ_W-1:0]         freq_fixed,
	output logic                                from_rest,
	output logic                                range_error,
	output logic                                count_overflow,
	output logic                                last_of_run,
	output logic                                end_of_sequence
);

	nprf_pkg::ctrl_cmd_t  cmd;
	nprf_pkg::ctrl_stat_t stat;

	nprf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	nprf_dp #(
		.MAX_LEADING_RESTS (MAX_LEADING_RESTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.is_rest         (is_rest),
		.note_letter     (note_letter),
		.accidental      (accidental),
		.octave          (octave),
		.last_token      (last_token),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.midi_fixed      (midi_fixed),
		.midi_rounded    (midi_rounded),
		.freq_fixed      (freq_fixed),
		.from_rest       (from_rest),
		.range_error     (range_error),
		.count_overflow  (count_overflow),
		.last_of_run     (last_of_run),
		.end_of_sequence (end_of_sequence)
	);

endmodule

[sv/nprf_ctrl.sv]
// ----------------------------------------------------------------------------
// nprf_ctrl
// Sequencer: takes a token, then issues the filled-rest and final results.
// ----------------------------------------------------------------------------
module nprf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  nprf_pkg::ctrl_stat_t stat,
	output nprf_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FILL,
		S_FINAL
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (stat.fill_start) begin
						state_nxt = S_FILL;
					end else if (stat.final_start) begin
						state_nxt = S_FINAL;
					end
				end
			end
			S_FILL: begin
				if (stat.slot_free) begin
					cmd.emit_fill = 1'b1;
					// a rest-only sequence ends on its last filled rest
					if (stat.cnt_one) begin
						state_nxt = stat.tok_rest ? S_IDLE : S_FINAL;
					end
				end
			end
			S_FINAL: begin
				if (stat.slot_free) begin
					cmd.emit_final = 1'b1;
					state_nxt      = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[sv/nprf_dp.sv]
// ----------------------------------------------------------------------------
// nprf_dp
// Datapath: token register, MIDI computation, sequence state, output register.
// ----------------------------------------------------------------------------
module nprf_dp #(
	parameter int MAX_LEADING_RESTS = 63
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nprf_pkg::ctrl_cmd_t                 cmd,
	output nprf_pkg::ctrl_stat_t                stat,
	input  logic                                is_rest,
	input  logic [nprf_pkg::LETTER_W-1:0]       note_letter,
	input  logic [nprf_pkg::ACC_W-1:0]          accidental,
	input  logic signed [nprf_pkg::OCT_W-1:0]   octave,
	input  logic                                last_token,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [nprf_pkg::MIDI_FIX_W-1:0]     midi_fixed,
	output logic [nprf_pkg::MIDI_W-1:0]         midi_rounded,
	output logic [nprf_pkg::FREQ_W-1:0]         freq_fixed,
	output logic                                from_rest,
	output logic                                range_error,
	output logic                                count_overflow,
	output logic                                last_of_run,
	output logic                                end_of_sequence
);

	localparam int PW = $clog2(MAX_LEADING_RESTS + 1);
	localparam logic [PW-1:0] PEND_MAX = PW'(MAX_LEADING_RESTS);

	// token register
	logic                        tok_rest_q;
	logic                        tok_last_q;
	logic [nprf_pkg::MIDI_W-1:0] midi_q;
	logic                        rerr_q;

	// sequence state
	logic [nprf_pkg::MIDI_W-1:0] prev_q;
	logic                        have_note_q;
	logic [PW-1:0]               pending_q;
	logic                        pend_ovf_q;
	logic [PW-1:0]               cnt_q;

	// output register
	logic                            out_valid_q;
	logic [nprf_pkg::MIDI_FIX_W-1:0] midi_fixed_q;
	logic [nprf_pkg::MIDI_W-1:0]     midi_rounded_q;
	logic [nprf_pkg::FREQ_W-1:0]     freq_fixed_q;
	logic                            from_rest_q;
	logic                            range_error_q;
	logic                            count_overflow_q;
	logic                            last_of_run_q;
	logic                            end_of_sequence_q;

	// MIDI number of the incoming token
	logic [3:0]                  pc_base;
	logic [3:0]                  pc;
	logic signed [9:0]           oct_x;
	logic signed [9:0]           midi_s;
	logic [nprf_pkg::MIDI_W-1:0] midi_c;
	logic                        rerr_c;

	always_comb begin
		pc_base = nprf_pkg::letter_base(note_letter);
		case (accidental)
			nprf_pkg::ACC_SHARP: pc = (pc_base == 4'd11) ? 4'd0 : pc_base + 4'd1;
			nprf_pkg::ACC_FLAT:  pc = (pc_base == 4'd0) ? 4'd11 : pc_base - 4'd1;
			default:             pc = pc_base;
		endcase
		oct_x  = $signed({{5{octave[nprf_pkg::OCT_W-1]}}, octave}) + 10'sd1;
		midi_s = (oct_x <<< 3) + (oct_x <<< 2) + $signed({6'd0, pc});
		if (midi_s > 10'sd127) begin
			midi_c = nprf_pkg::MIDI_MAX;
			rerr_c = 1'b1;
		end else if (midi_s < 10'sd0) begin
			midi_c = '0;
			rerr_c = 1'b1;
		end else begin
			midi_c = midi_s[nprf_pkg::MIDI_W-1:0];
			rerr_c = 1'b0;
		end
	end

	logic [PW-1:0] pend_inc;
	logic          pend_sat;
	logic          slot_free;
	logic          cnt_one;
	logic          finish_fill;
	logic          emit;
	logic          emit_eos;

	assign pend_sat    = (pending_q == PEND_MAX);
	assign pend_inc    = pend_sat ? pending_q : pending_q + PW'(1);
	assign slot_free   = !out_valid_q || out_ready;
	assign cnt_one     = (cnt_q == PW'(1));
	assign finish_fill = cmd.emit_fill && cnt_one && tok_rest_q;
	assign emit        = cmd.emit_fill || cmd.emit_final;
	assign emit_eos    = (cmd.emit_final && tok_last_q) || finish_fill;

	always_comb begin
		stat.slot_free   = slot_free;
		stat.fill_start  = !have_note_q && (is_rest ? last_token : (pending_q != '0));
		stat.final_start = !is_rest || have_note_q;
		stat.cnt_one     = cnt_one;
		stat.tok_rest    = tok_rest_q;
	end

	// token payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			midi_q <= midi_c;
			rerr_q <= rerr_c;
		end
	end

	// token flags and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_rest_q  <= 1'b0;
			tok_last_q  <= 1'b0;
			prev_q      <= '0;
			have_note_q <= 1'b0;
			pending_q   <= '0;
			pend_ovf_q  <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cmd.capture) begin
				tok_rest_q <= is_rest;
				tok_last_q <= last_token;
				// fill count: held rests for a note, held rests plus this one at the end
				cnt_q      <= is_rest ? pend_inc : pending_q;
			end else if (cmd.emit_fill) begin
				cnt_q <= cnt_q - PW'(1);
			end

			if ((cmd.emit_final || finish_fill) && tok_last_q) begin
				prev_q      <= '0;
				have_note_q <= 1'b0;
				pending_q   <= '0;
				pend_ovf_q  <= 1'b0;
			end else if (cmd.emit_final && !tok_rest_q) begin
				prev_q      <= midi_q;
				have_note_q <= 1'b1;
				pending_q   <= '0;
				pend_ovf_q  <= 1'b0;
			end else if (cmd.capture && is_rest && !have_note_q) begin
				pending_q <= pend_inc;
				if (pend_sat) begin
					pend_ovf_q <= 1'b1;
				end
			end
		end
	end

	// output register
	logic [nprf_pkg::MIDI_W-1:0] pitch_sel;
	logic                        use_default;

	always_comb begin
		use_default = cmd.emit_fill && tok_rest_q;
		if (cmd.emit_final && tok_rest_q) begin
			pitch_sel = prev_q;
		end else begin
			pitch_sel = midi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (use_default) begin
				midi_fixed_q   <= nprf_pkg::DEFAULT_MIDI_FIXED;
				midi_rounded_q <= nprf_pkg::DEFAULT_MIDI_ROUNDED;
				freq_fixed_q   <= nprf_pkg::DEFAULT_FREQ_FIXED;
			end else begin
				midi_fixed_q   <= {pitch_sel, 8'd0};
				midi_rounded_q <= pitch_sel;
				freq_fixed_q   <= nprf_pkg::FREQ_TABLE[pitch_sel];
			end
			from_rest_q       <= cmd.emit_fill || tok_rest_q;
			range_error_q     <= cmd.emit_final && !tok_rest_q && rerr_q;
			count_overflow_q  <= cmd.emit_fill && pend_ovf_q;
			last_of_run_q     <= cmd.emit_final || finish_fill;
			end_of_sequence_q <= emit_eos;
		end
	end

	assign out_valid       = out_valid_q;
	assign midi_fixed      = midi_fixed_q;
	assign midi_rounded    = midi_rounded_q;
	assign freq_fixed      = freq_fixed_q;
	assign from_rest       = from_rest_q;
	assign range_error     = range_error_q;
	assign count_overflow  = count_overflow_q;
	assign last_of_run     = last_of_run_q;
	assign end_of_sequence = end_of_sequence_q;

	// never overwrite a result that has not been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !emit)
		else $error("result overwritten while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PEND_MAX)
		else $error("leading rest count above bound");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_fill |-> (cnt_q != '0))
		else $error("filled rest issued with empty count");

	// the end of a sequence leaves no note and no held rests behind
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_eos |=> (!have_note_q && pending_q == '0 && !pend_ovf_q))
		else $error("sequence state not cleared at end of sequence");

endmodule
